// ===== hw/rtl/i2a_pkg.sv =====
package i2a_pkg;

    // Default sizes
    localparam int BUFFER_CHARS_DEF = 32;
    localparam int VALUE_BITS_DEF   = 64;

    // Limits on output length, width and precision
    localparam int MAX_OUT   = 32;
    localparam int LIMIT_MAX = 32;

    // Radix codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_BIN = 2'd3;

    // ASCII characters
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_DIGIT,
        ST_FILL,
        ST_TRIM,
        ST_PFX_X,
        ST_PFX_0,
        ST_SIGN,
        ST_SETUP,
        ST_EMIT
    } state_t;

    // Saturate a 6-bit width or precision to the limit
    function automatic logic [5:0] sat_limit(input logic [5:0] v);
        sat_limit = (v > 6'(LIMIT_MAX)) ? 6'(LIMIT_MAX) : v;
    endfunction

    // Map one digit value to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            digit_char = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_formatter_top.sv =====
// Steps: in decimal the shift-add-3 converter runs over every value bit, then digits and fill
// zeros are written one at a time, then fill end, trim, two prefix steps with the alternate form,
// sign and setup; characters then leave one per cycle while m_tready does not stall the output.
// A new request is taken only when the sequencer is idle, so not before every character of the
// previous request has been loaded into the output register.
// Reset: synchronous active-low aresetn returns the sequencer to idle and empties the output.
module integer_to_ascii_formatter_top #(
    parameter int BUFFER_CHARS = i2a_pkg::BUFFER_CHARS_DEF,
    parameter int VALUE_BITS   = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request beat
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: magnitude[63:0], is_negative, precision[5:0], precision_given,
    // field_width[5:0], zero_pad, left_align, plus_sign, space_sign, alt_form, upper_case
    input  logic [87:0] s_tdata,
    // tuser from bit 0: base_code[1:0]
    input  logic [1:0]  s_tuser,
    // Character beat
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: out_char[7:0]
    output logic [7:0]  m_tdata,
    // tlast: last_char
    output logic        m_tlast
);

    localparam int CAP        = (BUFFER_CHARS < 32) ? BUFFER_CHARS : 32;
    localparam int LEN_W      = $clog2(CAP + 1);
    localparam int IDX_W      = $clog2(CAP);
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int WORK_W     = 4 * DEC_DIGITS;
    localparam int BIT_W      = $clog2(VALUE_BITS);

    i2a_pkg::state_t state_reg, state_next;

    // Request fields
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [WORK_W-1:0]     work_reg, work_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic                  neg_reg, plus_reg, space_reg, alt_reg, upper_reg;
    logic                  zp_reg, left_reg, pgiven_reg, zero_reg;
    logic [1:0]            base_reg;
    logic [5:0]            prec_reg, wid_reg;

    // Character buffer and emission counters
    logic [7:0]       buf_reg [CAP];
    logic             buf_we;
    logic [7:0]       buf_wdata;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [5:0]       total_reg, total_next;
    logic [5:0]       lead_reg, lead_next;
    logic [5:0]       pos_reg, pos_next;

    // Output register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    // Shared conditions
    logic                  s_beat, out_free, len_lt_cap, sign_any, conv_done;
    logic                  fill_go, digit_more, skip_digits, in_dec, in_zero;
    logic [5:0]            lenx, in_prec, in_wid;
    logic [3:0]            dig;
    logic [WORK_W-1:0]     work_sh, work_dd;
    logic [LEN_W-1:0]      len_trim;
    logic [5:0]            emit_k, total_calc;
    logic [5:0]            rd_full;
    logic [7:0]            sign_char;

    assign s_tready   = (state_reg == i2a_pkg::ST_IDLE);
    assign s_beat     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign lenx       = 6'(len_reg);
    assign len_lt_cap = (len_reg < LEN_W'(CAP));
    assign sign_any   = neg_reg || plus_reg || space_reg;
    assign conv_done  = (bit_cnt_reg == BIT_W'(VALUE_BITS - 1));
    assign fill_go    = len_lt_cap && ((lenx < prec_reg) || (zp_reg && (lenx < wid_reg)));
    assign skip_digits = pgiven_reg && zero_reg;
    assign in_dec     = (s_tuser == i2a_pkg::BASE_DEC);
    assign in_zero    = (s_tdata[VALUE_BITS-1:0] == '0);
    assign in_prec    = i2a_pkg::sat_limit(s_tdata[70:65]);
    assign in_wid     = i2a_pkg::sat_limit(s_tdata[77:72]);

    // Take the low digit and shift it out of the work register
    always_comb begin
        case (base_reg)
            i2a_pkg::BASE_OCT: begin
                dig     = {1'b0, work_reg[2:0]};
                work_sh = work_reg >> 3;
            end
            i2a_pkg::BASE_BIN: begin
                dig     = {3'b000, work_reg[0]};
                work_sh = work_reg >> 1;
            end
            default: begin
                dig     = work_reg[3:0];
                work_sh = work_reg >> 4;
            end
        endcase
    end
    assign digit_more = (work_sh != '0) && ((len_reg + LEN_W'(1)) < LEN_W'(CAP));

    // One shift-add-3 step over every BCD digit
    always_comb begin
        logic [WORK_W-1:0] adj;
        adj = work_reg;
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (work_reg[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = work_reg[4*d +: 4] + 4'd3;
            end
        end
        work_dd = {adj[WORK_W-2:0], bin_reg[VALUE_BITS-1]};
    end

    // Prefix trimming rule
    always_comb begin
        len_trim = len_reg;
        if (!pgiven_reg && (len_reg != '0) && ((lenx == prec_reg) || (lenx == wid_reg))) begin
            len_trim = len_reg - LEN_W'(1);
            if ((len_trim != '0) && (base_reg == i2a_pkg::BASE_HEX)) begin
                len_trim = len_trim - LEN_W'(1);
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            sign_char = i2a_pkg::CH_MINUS;
        end else if (plus_reg) begin
            sign_char = i2a_pkg::CH_PLUS;
        end else begin
            sign_char = i2a_pkg::CH_SPACE;
        end
    end

    assign total_calc = (zp_reg && !left_reg) ? lenx : ((wid_reg > lenx) ? wid_reg : lenx);
    assign emit_k     = pos_reg - lead_reg;
    assign rd_full    = lenx - 6'd1 - emit_k;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (s_beat) begin
                    if (in_dec) begin
                        state_next = i2a_pkg::ST_CONV;
                    end else if (s_tdata[71] && in_zero) begin
                        state_next = i2a_pkg::ST_FILL;
                    end else begin
                        state_next = i2a_pkg::ST_DIGIT;
                    end
                end
            end
            i2a_pkg::ST_CONV: begin
                if (conv_done) begin
                    state_next = skip_digits ? i2a_pkg::ST_FILL : i2a_pkg::ST_DIGIT;
                end
            end
            i2a_pkg::ST_DIGIT: begin
                if (!digit_more) begin
                    state_next = i2a_pkg::ST_FILL;
                end
            end
            i2a_pkg::ST_FILL: begin
                if (left_reg || !fill_go) begin
                    state_next = i2a_pkg::ST_TRIM;
                end
            end
            i2a_pkg::ST_TRIM:  state_next = alt_reg ? i2a_pkg::ST_PFX_X : i2a_pkg::ST_SIGN;
            i2a_pkg::ST_PFX_X: state_next = i2a_pkg::ST_PFX_0;
            i2a_pkg::ST_PFX_0: state_next = i2a_pkg::ST_SIGN;
            i2a_pkg::ST_SIGN:  state_next = i2a_pkg::ST_SETUP;
            i2a_pkg::ST_SETUP: begin
                state_next = (total_calc == 6'd0) ? i2a_pkg::ST_IDLE : i2a_pkg::ST_EMIT;
            end
            i2a_pkg::ST_EMIT: begin
                if (out_free && (pos_reg == total_reg - 6'd1)) begin
                    state_next = i2a_pkg::ST_IDLE;
                end
            end
            default: state_next = i2a_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output
    always_comb begin
        bin_next      = bin_reg;
        work_next     = work_reg;
        bit_cnt_next  = bit_cnt_reg;
        len_next      = len_reg;
        total_next    = total_reg;
        lead_next     = lead_reg;
        pos_next      = pos_reg;
        buf_we        = 1'b0;
        buf_wdata     = i2a_pkg::CH_ZERO;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        unique case (state_reg)
            i2a_pkg::ST_IDLE: begin
                bin_next     = s_tdata[VALUE_BITS-1:0];
                work_next    = in_dec ? '0 : WORK_W'(s_tdata[VALUE_BITS-1:0]);
                bit_cnt_next = '0;
                len_next     = '0;
            end
            i2a_pkg::ST_CONV: begin
                work_next    = work_dd;
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
            end
            i2a_pkg::ST_DIGIT: begin
                buf_we    = 1'b1;
                buf_wdata = i2a_pkg::digit_char(dig, upper_reg);
                work_next = work_sh;
                len_next  = len_reg + LEN_W'(1);
            end
            i2a_pkg::ST_FILL: begin
                if (!left_reg && fill_go) begin
                    buf_we   = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
            end
            i2a_pkg::ST_TRIM: begin
                if (alt_reg) begin
                    len_next = len_trim;
                end
            end
            i2a_pkg::ST_PFX_X: begin
                if (len_lt_cap &&
                    (base_reg == i2a_pkg::BASE_HEX || base_reg == i2a_pkg::BASE_BIN)) begin
                    buf_we    = 1'b1;
                    buf_wdata = (base_reg == i2a_pkg::BASE_BIN) ? i2a_pkg::CH_LOWER_B :
                                (upper_reg ? i2a_pkg::CH_UPPER_X : i2a_pkg::CH_LOWER_X);
                    len_next  = len_reg + LEN_W'(1);
                end
            end
            i2a_pkg::ST_PFX_0: begin
                if (len_lt_cap) begin
                    buf_we   = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
            end
            i2a_pkg::ST_SIGN: begin
                if (len_lt_cap && sign_any) begin
                    buf_we    = 1'b1;
                    buf_wdata = sign_char;
                    len_next  = len_reg + LEN_W'(1);
                end
            end
            i2a_pkg::ST_SETUP: begin
                total_next = total_calc;
                lead_next  = (left_reg || zp_reg) ? 6'd0 : total_calc - lenx;
                pos_next   = 6'd0;
            end
            i2a_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (pos_reg == total_reg - 6'd1);
                    if ((pos_reg < lead_reg) || (emit_k >= lenx)) begin
                        m_tdata_next = i2a_pkg::CH_SPACE;
                    end else begin
                        m_tdata_next = buf_reg[rd_full[IDX_W-1:0]];
                    end
                    pos_next = pos_reg + 6'd1;
                end
            end
            default: begin
                len_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= i2a_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Latch request fields on the input beat
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            neg_reg    <= s_tdata[64];
            prec_reg   <= in_prec;
            pgiven_reg <= s_tdata[71];
            zp_reg     <= s_tdata[78];
            left_reg   <= s_tdata[79];
            plus_reg   <= s_tdata[80];
            space_reg  <= s_tdata[81];
            alt_reg    <= s_tdata[82] && !in_zero;
            upper_reg  <= s_tdata[83];
            base_reg   <= s_tuser;
            zero_reg   <= in_zero;
            if (!s_tdata[79] && (in_wid != 6'd0) && s_tdata[78] &&
                (s_tdata[64] || s_tdata[80] || s_tdata[81])) begin
                wid_reg <= in_wid - 6'd1;
            end else begin
                wid_reg <= in_wid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        work_reg    <= work_next;
        bit_cnt_reg <= bit_cnt_next;
        len_reg     <= len_next;
        total_reg   <= total_next;
        lead_reg    <= lead_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (buf_we) begin
            buf_reg[len_reg[IDX_W-1:0]] <= buf_wdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == i2a_pkg::ST_EMIT) |-> (pos_reg < total_reg))
        else $error("emission position past request length");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != i2a_pkg::ST_IDLE) |-> (len_reg <= LEN_W'(CAP)))
        else $error("buffer length beyond capacity");

    a_total_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == i2a_pkg::ST_EMIT) |-> (total_reg <= 6'(i2a_pkg::MAX_OUT)))
        else $error("request longer than output limit");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> (state_reg != i2a_pkg::ST_IDLE))
        else $error("sequencer idle right after request beat");

endmodule

// ===== dv/integer_to_ascii_formatter_top_tb.sv =====
module integer_to_ascii_formatter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Working buffer length, bounded by the output limit
    localparam int CHAR_CAP  = (i2a_pkg::BUFFER_CHARS_DEF < i2a_pkg::MAX_OUT) ?
                               i2a_pkg::BUFFER_CHARS_DEF : i2a_pkg::MAX_OUT;
    localparam int RAND_REQS = 198;
    localparam int TAIL_REQS = 30;
    localparam int DRAIN_CYC = 300;

    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        logic [1:0]  base;
        logic [5:0]  prec;
        logic        pgiven;
        logic [5:0]  width;
        logic        zp;
        logic        left;
        logic        plus;
        logic        space;
        logic        alt;
        logic        upper;
    } fmt_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    fmt_req_t   pend_reqs [$];
    char_beat_t exp_chars [$];
    fmt_req_t   cur_req;
    int         gap_cnt    = 0;
    int         stall_cnt  = 0;
    logic       src_idle   = 1'b1;
    logic       sink_idle  = 1'b1;
    int         errors     = 0;

    integer_to_ascii_formatter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // tdata from bit 0: magnitude, is_negative, precision, precision_given, field_width,
    // zero_pad, left_align, plus_sign, space_sign, alt_form, upper_case, zero fill
    function automatic logic [87:0] pack_req(input fmt_req_t r);
        pack_req = {4'd0, r.upper, r.alt, r.space, r.plus, r.left, r.zp,
                    r.width, r.pgiven, r.prec, r.neg, r.mag};
    endfunction

    function automatic fmt_req_t mk_req(input logic [63:0] mag, input int neg,
                                        input logic [1:0] base, input int prec,
                                        input int pgiven, input int width,
                                        input int zp, input int left,
                                        input int plus, input int space,
                                        input int alt, input int upper);
        fmt_req_t r;
        r.mag    = mag;
        r.neg    = 1'(neg);
        r.base   = base;
        r.prec   = 6'(prec);
        r.pgiven = 1'(pgiven);
        r.width  = 6'(width);
        r.zp     = 1'(zp);
        r.left   = 1'(left);
        r.plus   = 1'(plus);
        r.space  = 1'(space);
        r.alt    = 1'(alt);
        r.upper  = 1'(upper);
        return r;
    endfunction

    // Build the characters of one conversion and queue them in output order
    task automatic predict_chars(input fmt_req_t r);
        logic [7:0]  digs [0:63];
        logic [7:0]  line_q [$];
        logic [63:0] v;
        logic [63:0] radix;
        logic [3:0]  d;
        logic        alt_on;
        logic        more;
        int          len;
        int          n;
        int          prec;
        int          width;
        int          i;
        char_beat_t  b;

        v      = r.mag;
        alt_on = r.alt && (r.mag != 64'd0);
        case (r.base)
            i2a_pkg::BASE_HEX: radix = 64'd16;
            i2a_pkg::BASE_OCT: radix = 64'd8;
            i2a_pkg::BASE_BIN: radix = 64'd2;
            default:           radix = 64'd10;
        endcase
        prec  = (r.prec > i2a_pkg::LIMIT_MAX) ? i2a_pkg::LIMIT_MAX : int'(r.prec);
        width = (r.width > i2a_pkg::LIMIT_MAX) ? i2a_pkg::LIMIT_MAX : int'(r.width);
        len   = 0;
        n     = 0;

        // Digits, least significant first; zero with explicit precision gives none
        if (!r.pgiven || v != 64'd0) begin
            more = 1'b1;
            while (more) begin
                d = 4'(v % radix);
                if (d < 4'd10)
                    digs[len] = i2a_pkg::CH_ZERO + 8'(d);
                else
                    digs[len] = (r.upper ? i2a_pkg::CH_UPPER_A : i2a_pkg::CH_LOWER_A) +
                                8'(d) - 8'd10;
                len++;
                v = v / radix;
                more = (v != 64'd0) && (len < CHAR_CAP);
            end
        end

        // Precision zeros, then zero fill up to the width less one for the sign
        if (!r.left) begin
            if (width != 0 && r.zp && (r.neg || r.plus || r.space))
                width--;
            while (len < prec && len < CHAR_CAP) begin
                digs[len] = i2a_pkg::CH_ZERO;
                len++;
            end
            while (r.zp && len < width && len < CHAR_CAP) begin
                digs[len] = i2a_pkg::CH_ZERO;
                len++;
            end
        end

        // Prefix, trimming fill that already reaches the precision or width
        if (alt_on) begin
            if (!r.pgiven && len != 0 && (len == prec || len == width)) begin
                len--;
                if (len != 0 && r.base == i2a_pkg::BASE_HEX)
                    len--;
            end
            if (r.base == i2a_pkg::BASE_HEX && len < CHAR_CAP) begin
                digs[len] = r.upper ? i2a_pkg::CH_UPPER_X : i2a_pkg::CH_LOWER_X;
                len++;
            end else if (r.base == i2a_pkg::BASE_BIN && len < CHAR_CAP) begin
                digs[len] = i2a_pkg::CH_LOWER_B;
                len++;
            end
            if (len < CHAR_CAP) begin
                digs[len] = i2a_pkg::CH_ZERO;
                len++;
            end
        end

        if (len < CHAR_CAP) begin
            if (r.neg) begin
                digs[len] = i2a_pkg::CH_MINUS;
                len++;
            end else if (r.plus) begin
                digs[len] = i2a_pkg::CH_PLUS;
                len++;
            end else if (r.space) begin
                digs[len] = i2a_pkg::CH_SPACE;
                len++;
            end
        end

        // Leading spaces, reversed buffer, trailing spaces
        if (!r.left && !r.zp) begin
            for (i = len; i < width && n < i2a_pkg::MAX_OUT; i++) begin
                line_q.push_back(i2a_pkg::CH_SPACE);
                n++;
            end
        end
        while (len != 0 && n < i2a_pkg::MAX_OUT) begin
            len--;
            line_q.push_back(digs[len]);
            n++;
        end
        if (r.left) begin
            while (n < width && n < i2a_pkg::MAX_OUT) begin
                line_q.push_back(i2a_pkg::CH_SPACE);
                n++;
            end
        end

        for (i = 0; i < line_q.size(); i++) begin
            b.ch   = line_q[i];
            b.last = (i == line_q.size() - 1);
            exp_chars.push_back(b);
        end
    endtask

    // Request driver: hold a beat until taken, then advance or idle for a burst
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                predict_chars(cur_req);
                if ($urandom_range(0, 39) == 0)
                    src_idle = ~src_idle;
                if (src_idle && pend_reqs.size() >= TAIL_REQS && $urandom_range(0, 2) == 0)
                    gap_cnt = $urandom_range(1, 19);
            end
            if (gap_cnt > 0) begin
                gap_cnt--;
                s_tvalid <= 1'b0;
            end else if (pend_reqs.size() != 0) begin
                cur_req = pend_reqs.pop_front();
                s_tdata  <= pack_req(cur_req);
                s_tuser  <= cur_req.base;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Character monitor: stall in bursts, check each beat against the oldest expected one
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (exp_chars.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected char beat: char %h last %b", m_tdata, m_tlast);
                end else if (exp_chars[0].ch !== m_tdata || exp_chars[0].last !== m_tlast) begin
                    errors++;
                    if (errors <= 10)
                        $display({"char beat mismatch: expected char %h last %b, ",
                                  "got char %h last %b"},
                                 exp_chars[0].ch, exp_chars[0].last, m_tdata, m_tlast);
                    void'(exp_chars.pop_front());
                end else begin
                    void'(exp_chars.pop_front());
                end
            end
            if ($urandom_range(0, 299) == 0)
                sink_idle = ~sink_idle;
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else if (sink_idle && pend_reqs.size() >= TAIL_REQS &&
                         $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("integer_to_ascii_formatter_top verification failed");
        $finish;
    end

    initial begin
        fmt_req_t r;
        int       k;
        int       sel;

        // Directed: defaults, zero cases, extremes, every radix and flag, saturation
        pend_reqs.push_back(mk_req(64'd0, 0, i2a_pkg::BASE_DEC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd0, 0, i2a_pkg::BASE_DEC, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd0, 0, i2a_pkg::BASE_HEX, 0, 1, 5, 0, 0, 0, 0, 1, 0));
        pend_reqs.push_back(mk_req(64'd0, 0, i2a_pkg::BASE_OCT, 3, 0, 0, 0, 0, 0, 0, 1, 0));
        pend_reqs.push_back(mk_req('1, 1, i2a_pkg::BASE_DEC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pend_reqs.push_back(mk_req('1, 0, i2a_pkg::BASE_HEX, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        pend_reqs.push_back(mk_req('1, 0, i2a_pkg::BASE_OCT, 0, 0, 0, 0, 0, 1, 0, 1, 0));
        pend_reqs.push_back(mk_req('1, 1, i2a_pkg::BASE_BIN, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        pend_reqs.push_back(mk_req(64'd42, 0, i2a_pkg::BASE_DEC, 63, 1, 0, 0, 0, 0, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd42, 1, i2a_pkg::BASE_DEC, 0, 0, 63, 0, 0, 0, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd42, 0, i2a_pkg::BASE_DEC, 33, 0, 33, 1, 0, 1, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd123, 1, i2a_pkg::BASE_DEC, 0, 0, 10, 1, 0, 0, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd123, 0, i2a_pkg::BASE_DEC, 0, 0, 10, 0, 1, 1, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd7, 0, i2a_pkg::BASE_DEC, 0, 0, 4, 0, 0, 0, 1, 0, 0));
        pend_reqs.push_back(mk_req(64'h1, 0, i2a_pkg::BASE_HEX, 4, 0, 0, 0, 0, 0, 0, 1, 0));
        pend_reqs.push_back(mk_req(64'hab, 0, i2a_pkg::BASE_HEX, 0, 0, 8, 1, 0, 0, 0, 1, 1));
        pend_reqs.push_back(mk_req(64'h5, 0, i2a_pkg::BASE_BIN, 0, 0, 6, 1, 0, 0, 1, 1, 0));
        pend_reqs.push_back(mk_req(64'd9, 0, i2a_pkg::BASE_DEC, 5, 1, 8, 1, 0, 1, 0, 0, 0));
        pend_reqs.push_back(mk_req(64'd8, 0, i2a_pkg::BASE_OCT, 3, 0, 0, 0, 0, 0, 0, 1, 0));
        pend_reqs.push_back(mk_req(64'd10, 0, i2a_pkg::BASE_DEC, 0, 0, 3, 0, 0, 0, 0, 1, 0));
        pend_reqs.push_back(mk_req(64'hdead, 1, i2a_pkg::BASE_HEX, 2, 1, 12, 0, 1, 1, 1, 1, 0));
        pend_reqs.push_back(mk_req(64'd0, 0, i2a_pkg::BASE_BIN, 0, 1, 0, 1, 0, 0, 1, 0, 0));

        // Random requests, mostly small widths and precisions
        for (k = 0; k < RAND_REQS; k++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                r.mag = 64'd0;
            else if (sel == 1)
                r.mag = '1;
            else
                r.mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            r.neg    = 1'($urandom_range(0, 1));
            r.base   = 2'($urandom_range(0, 3));
            r.prec   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
                                                     6'($urandom_range(0, 10));
            r.pgiven = 1'($urandom_range(0, 1));
            r.width  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
                                                     6'($urandom_range(0, 24));
            r.zp     = 1'($urandom_range(0, 1));
            r.left   = 1'($urandom_range(0, 1));
            r.plus   = 1'($urandom_range(0, 1));
            r.space  = 1'($urandom_range(0, 1));
            r.alt    = 1'($urandom_range(0, 1));
            r.upper  = 1'($urandom_range(0, 1));
            pend_reqs.push_back(r);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: every request taken, every character seen, then a quiet tail
        while (pend_reqs.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (exp_chars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (exp_chars.size() != 0)
            $display("%0d expected char beats never arrived", exp_chars.size());
        if (errors == 0 && exp_chars.size() == 0) begin
            $display("integer_to_ascii_formatter_top verification clean");
        end else begin
            $display("integer_to_ascii_formatter_top verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/i2a_pkg.sv
hw/rtl/integer_to_ascii_formatter_top.sv
dv/integer_to_ascii_formatter_top_tb.sv
